// ===== rtl/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// Mutating step sequencer package
// Shared widths, codes, modulo constants and the mutation microprogram.
// ----------------------------------------------------------------------------
package mss_pkg;

	localparam int unsigned OUTPUTS   = 4;
	localparam int unsigned BASE_REGS = 4;
	localparam int unsigned FIRE_W    = 4;
	localparam int unsigned OUT_VEC_W = (OUTPUTS > FIRE_W) ? OUTPUTS : FIRE_W;
	localparam int unsigned OI_W      = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;

	localparam int unsigned NUM_STEPS  = 16;
	localparam int unsigned STEP_W     = 4;
	localparam int unsigned PAT_W      = 16;
	localparam int unsigned LFSR_W     = 32;
	localparam int unsigned DUE_W      = 32;
	localparam int unsigned TEMPO_W    = 16;
	localparam int unsigned INTERVAL_W = 14;
	localparam int unsigned LEVEL_W    = 7;
	localparam int unsigned DRAW_W     = 15;
	localparam int unsigned FRAC_W     = 20;
	localparam int unsigned RECIP_W    = 21;
	localparam int unsigned MOD_W      = 7;
	localparam int unsigned CNT_W      = 2;
	localparam int unsigned UPC_W      = 4;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned IN_DATA_W  = 64;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 24;

	localparam logic [LFSR_W-1:0]     LFSR_TAPS   = 32'h8020_0003;
	localparam logic [LFSR_W-1:0]     SEED_RESET  = 32'h0000_0001;
	localparam logic [INTERVAL_W-1:0] MIN_STEP_MS = 14'd5;
	localparam logic [LEVEL_W-1:0]    LEVEL_MAX   = 7'd100;
	localparam logic [LEVEL_W-1:0]    LEVEL_STEP  = 7'd10;
	localparam logic [LEVEL_W-1:0]    LEVEL_BACK  = 7'd90;

	localparam int unsigned MOD_FLIPS = 3;
	localparam int unsigned MOD_PCT   = 100;

	localparam logic [RECIP_W-1:0] RECIP_FLIPS = RECIP_W'((1 << FRAC_W) / MOD_FLIPS);
	localparam logic [RECIP_W-1:0] RECIP_PCT   = RECIP_W'((1 << FRAC_W) / MOD_PCT);
	localparam logic [RECIP_W-1:0] RECIP_OUT   = RECIP_W'((1 << FRAC_W) / OUTPUTS);
	localparam logic [RECIP_W-1:0] RECIP_STEP  = RECIP_W'((1 << FRAC_W) / NUM_STEPS);

	typedef enum logic [1:0] {
		MODE_TIME   = 2'd0,
		MODE_BUTTON = 2'd1,
		MODE_RESET  = 2'd2,
		MODE_SET    = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_A = 3'd0,
		REG_BASE_B = 3'd1,
		REG_BASE_C = 3'd2,
		REG_BASE_D = 3'd3,
		REG_SEED   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MS_FLIPS = 2'd0,
		MS_PCT   = 2'd1,
		MS_OUT   = 2'd2,
		MS_STEP  = 2'd3
	} mod_sel_t;

	typedef enum logic [2:0] {
		A_NONE  = 3'd0,
		A_COUNT = 3'd1,
		A_TESTL = 3'd2,
		A_TESTH = 3'd3,
		A_OI    = 3'd4,
		A_FLIP  = 3'd5,
		A_BJ    = 3'd6,
		A_BK    = 3'd7
	} act_t;

	typedef enum logic [1:0] {
		BR_NEXT = 2'd0,
		BR_FAIL = 2'd1,
		BR_LOOP = 2'd2,
		BR_END  = 2'd3
	} br_t;

	typedef struct packed {
		logic             draw;
		mod_sel_t         msel;
		act_t             act;
		br_t              br;
		logic [UPC_W-1:0] target;
	} uword_t;

	localparam logic [UPC_W-1:0] UA_COUNT = 4'd0;
	localparam logic [UPC_W-1:0] UA_TESTL = 4'd1;
	localparam logic [UPC_W-1:0] UA_OI1   = 4'd2;
	localparam logic [UPC_W-1:0] UA_FLIP  = 4'd3;
	localparam logic [UPC_W-1:0] UA_LOOP  = 4'd4;
	localparam logic [UPC_W-1:0] UA_TESTH = 4'd5;
	localparam logic [UPC_W-1:0] UA_OI2   = 4'd6;
	localparam logic [UPC_W-1:0] UA_BJ    = 4'd7;
	localparam logic [UPC_W-1:0] UA_BK    = 4'd8;
	localparam logic [UPC_W-1:0] UA_END   = 4'd9;

	function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
		uword_t w;
		w = '{1'b0, MS_STEP, A_NONE, BR_END, UA_END};
		case (pc)
			UA_COUNT: w = '{1'b1, MS_FLIPS, A_COUNT, BR_NEXT, UA_TESTL};
			UA_TESTL: w = '{1'b1, MS_PCT,   A_TESTL, BR_FAIL, UA_LOOP};
			UA_OI1:   w = '{1'b1, MS_OUT,   A_OI,    BR_NEXT, UA_FLIP};
			UA_FLIP:  w = '{1'b1, MS_STEP,  A_FLIP,  BR_NEXT, UA_LOOP};
			UA_LOOP:  w = '{1'b0, MS_STEP,  A_NONE,  BR_LOOP, UA_TESTL};
			UA_TESTH: w = '{1'b1, MS_PCT,   A_TESTH, BR_FAIL, UA_END};
			UA_OI2:   w = '{1'b1, MS_OUT,   A_OI,    BR_NEXT, UA_BJ};
			UA_BJ:    w = '{1'b1, MS_STEP,  A_BJ,    BR_NEXT, UA_BK};
			UA_BK:    w = '{1'b1, MS_STEP,  A_BK,    BR_NEXT, UA_END};
			UA_END:   w = '{1'b0, MS_STEP,  A_NONE,  BR_END,  UA_END};
			default:  w = '{1'b0, MS_STEP,  A_NONE,  BR_END,  UA_END};
		endcase
		return w;
	endfunction

	function automatic logic [MOD_W-1:0] mod_value(input mod_sel_t sel);
		logic [MOD_W-1:0] c;
		case (sel)
			MS_FLIPS: c = MOD_W'(MOD_FLIPS);
			MS_PCT:   c = MOD_W'(MOD_PCT);
			MS_OUT:   c = MOD_W'(OUTPUTS);
			MS_STEP:  c = MOD_W'(NUM_STEPS);
			default:  c = MOD_W'(NUM_STEPS);
		endcase
		return c;
	endfunction

	function automatic logic [RECIP_W-1:0] mod_recip(input mod_sel_t sel);
		logic [RECIP_W-1:0] r;
		case (sel)
			MS_FLIPS: r = RECIP_FLIPS;
			MS_PCT:   r = RECIP_PCT;
			MS_OUT:   r = RECIP_OUT;
			MS_STEP:  r = RECIP_STEP;
			default:  r = RECIP_STEP;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/mutating_step_sequencer.sv =====
// ----------------------------------------------------------------------------
// Mutating step sequencer
// Sixteen-step rhythm sequencer with random pattern drift at each bar start.
// ----------------------------------------------------------------------------
// The result is registered in the cycle after the input transaction is accepted.
// A time update that plays step 0 with drift on runs the mutation microprogram
// first, and that result is registered when the program's end word executes.
// Throughput: one transaction per cycle otherwise, set by the output register
// and held back while the output is stalled.
// Reset: clears the step counter, drift state and patterns and loads the LFSR
// with 1.
module mutating_step_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// now_ms, tempo_interval_ms, step_restart, reload_patterns, set_active,
	// set_level, set_ramp_up, zero fill
	input  logic [mss_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic [mss_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// fire_mask, stepped, played_step, drift_on, drift_level, ramping_up,
	// zero fill
	output logic [mss_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                           cfg_we,
	input  logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mss_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mss_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t st_q;

	logic [PAT_W-1:0]   base_q [BASE_REGS];
	logic [PAT_W-1:0]   pat_q [OUTPUTS];
	logic [LFSR_W-1:0]  lfsr_q;
	logic [STEP_W-1:0]  step_q;
	logic [DUE_W-1:0]   due_q;
	logic               due_valid_q;
	logic               drift_q;
	logic [LEVEL_W-1:0] level_q;
	logic               rising_q;

	logic [UPC_W-1:0]  pc_q;
	logic [1:0]        ph_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DRAW_W-1:0] x_q;
	logic [DRAW_W-1:0] q_q;
	logic [OI_W-1:0]   oi_q;
	logic [PAT_W-1:0]  mask_q;

	logic               m_valid_q;
	logic [FIRE_W-1:0]  out_fire_q;
	logic               out_stepped_q;
	logic [STEP_W-1:0]  out_played_q;
	logic               out_drift_q;
	logic [LEVEL_W-1:0] out_level_q;
	logic               out_rising_q;

	mode_t               in_mode;
	logic [DUE_W-1:0]    in_now;
	logic [TEMPO_W-1:0]  in_tempo;
	logic                in_sync;
	logic                in_reload;
	logic                in_set_active;
	logic [LEVEL_W-1:0]  in_set_level;
	logic                in_set_ramp;

	logic                accept;
	logic                res_load;
	logic [INTERVAL_W-1:0] interval;
	logic [DUE_W-1:0]    due_eff;
	logic [DUE_W-1:0]    due_add;
	logic [DUE_W-1:0]    now_add;
	logic [DUE_W-1:0]    due_next;
	logic                step_due;
	logic [STEP_W-1:0]   step_eff;
	logic                need_mut;
	logic [PAT_W-1:0]    pat_load [OUTPUTS];
	logic [PAT_W-1:0]    pat_eff [OUTPUTS];
	logic [STEP_W-1:0]   fire_idx;
	logic [OUT_VEC_W-1:0] fire_vec;

	logic                drift_d;
	logic [LEVEL_W-1:0]  level_d;
	logic                rising_d;
	logic [LEVEL_W:0]    level_up;

	uword_t              uw;
	logic                exec;
	logic [LFSR_W-1:0]   lfsr_next;
	logic [MOD_W-1:0]    csel;
	logic [RECIP_W-1:0]  rsel;
	logic [DRAW_W+RECIP_W-1:0] prod;
	logic [DRAW_W+MOD_W-1:0]   qc;
	logic [DRAW_W-1:0]   r_raw;
	logic [MOD_W:0]      r_low;
	logic [MOD_W-1:0]    r;
	logic                cond;
	logic [PAT_W-1:0]    bit_r;

	assign in_mode       = mode_t'(s_axis_tuser);
	assign in_now        = s_axis_tdata[31:0];
	assign in_tempo      = s_axis_tdata[47:32];
	assign in_sync       = s_axis_tdata[48];
	assign in_reload     = s_axis_tdata[49];
	assign in_set_active = s_axis_tdata[50];
	assign in_set_level  = s_axis_tdata[57:51];
	assign in_set_ramp   = s_axis_tdata[58];

	assign s_axis_tready = (st_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign res_load      = (accept && !((in_mode == MODE_TIME) && need_mut)) ||
		(exec && (uw.br == BR_END));

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'b0, out_rising_q, out_level_q, out_drift_q, out_played_q,
		out_stepped_q, out_fire_q};

	always_comb begin
		interval = in_tempo[TEMPO_W-1:2];
		if (interval < MIN_STEP_MS) begin
			interval = MIN_STEP_MS;
		end
		due_eff  = due_valid_q ? due_q : in_now;
		step_due = (in_now >= due_eff);
		due_add  = due_eff + DUE_W'(interval);
		now_add  = in_now + DUE_W'(interval);
		due_next = (due_add < in_now) ? now_add : due_add;
		step_eff = in_sync ? '0 : step_q;
		need_mut = step_due && (step_eff == '0) && drift_q && (level_q != '0);
	end

	always_comb begin
		for (int i = 0; i < OUTPUTS; i++) begin
			if (i < BASE_REGS) begin
				pat_load[i] = base_q[i % BASE_REGS];
			end else begin
				pat_load[i] = '0;
			end
			pat_eff[i] = (st_q == ST_RUN) ? pat_q[i] : (in_reload ? pat_load[i] : pat_q[i]);
		end
		fire_idx = (st_q == ST_RUN) ? '0 : step_eff;
		fire_vec = '0;
		for (int i = 0; i < OUTPUTS; i++) begin
			fire_vec[i] = pat_eff[i][fire_idx];
		end
	end

	always_comb begin
		drift_d  = drift_q;
		level_d  = level_q;
		rising_d = rising_q;
		level_up = {1'b0, level_q} + {1'b0, LEVEL_STEP};
		case (in_mode)
			MODE_BUTTON: begin
				if (!drift_q) begin
					drift_d  = 1'b1;
					level_d  = LEVEL_STEP;
					rising_d = 1'b1;
				end else if (rising_q) begin
					if (level_q >= LEVEL_MAX) begin
						rising_d = 1'b0;
						level_d  = LEVEL_BACK;
					end else begin
						level_d = (level_up > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : level_up[LEVEL_W-1:0];
					end
				end else begin
					if (level_q == '0) begin
						rising_d = 1'b1;
						level_d  = LEVEL_STEP;
					end else begin
						level_d = (level_q < LEVEL_STEP) ? '0 : level_q - LEVEL_STEP;
					end
				end
			end
			MODE_RESET: begin
				drift_d  = 1'b0;
				level_d  = '0;
				rising_d = 1'b1;
			end
			MODE_SET: begin
				drift_d  = in_set_active;
				level_d  = (in_set_level > LEVEL_MAX) ? LEVEL_MAX : in_set_level;
				rising_d = in_set_ramp;
			end
			default: begin
				drift_d  = drift_q;
				level_d  = level_q;
				rising_d = rising_q;
			end
		endcase
	end

	always_comb begin
		uw        = ucode(pc_q);
		exec      = (st_q == ST_RUN) && (!uw.draw || (ph_q == 2'd2));
		lfsr_next = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);
		csel      = mod_value(uw.msel);
		rsel      = mod_recip(uw.msel);
		prod      = {{RECIP_W{1'b0}}, x_q} * {{DRAW_W{1'b0}}, rsel};
		qc        = {{MOD_W{1'b0}}, q_q} * {{DRAW_W{1'b0}}, csel};
		r_raw     = x_q - qc[DRAW_W-1:0];
		r_low     = r_raw[MOD_W:0];
		r         = (r_low >= {1'b0, csel}) ? MOD_W'(r_low - {1'b0, csel}) : r_low[MOD_W-1:0];
		case (uw.act)
			A_TESTL: cond = (r < level_q);
			A_TESTH: cond = (r < {1'b0, level_q[LEVEL_W-1:1]});
			default: cond = 1'b1;
		endcase
		bit_r = PAT_W'(1) << r[STEP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			for (int i = 0; i < BASE_REGS; i++) begin
				base_q[i] <= '0;
			end
			for (int i = 0; i < OUTPUTS; i++) begin
				pat_q[i] <= '0;
			end
			lfsr_q      <= SEED_RESET;
			step_q      <= '0;
			due_q       <= '0;
			due_valid_q <= 1'b0;
			drift_q     <= 1'b0;
			level_q     <= '0;
			rising_q    <= 1'b1;
			pc_q        <= UA_COUNT;
			ph_q        <= 2'd0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_BASE_A: base_q[0] <= cfg_data[PAT_W-1:0];
					REG_BASE_B: base_q[1] <= cfg_data[PAT_W-1:0];
					REG_BASE_C: base_q[2] <= cfg_data[PAT_W-1:0];
					REG_BASE_D: base_q[3] <= cfg_data[PAT_W-1:0];
					REG_SEED:   lfsr_q    <= cfg_data;
					default: ;
				endcase
			end
			if (res_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (accept) begin
				drift_q  <= drift_d;
				level_q  <= level_d;
				rising_q <= rising_d;
				case (in_mode)
					MODE_TIME: begin
						due_valid_q <= 1'b1;
						if (in_reload) begin
							for (int i = 0; i < OUTPUTS; i++) begin
								pat_q[i] <= pat_load[i];
							end
						end
						if (step_due) begin
							due_q  <= due_next;
							step_q <= step_eff + STEP_W'(1);
						end else begin
							step_q <= step_eff;
						end
						if (need_mut) begin
							st_q <= ST_RUN;
							pc_q <= UA_COUNT;
							ph_q <= 2'd0;
						end
					end
					MODE_RESET: begin
						step_q      <= '0;
						due_q       <= '0;
						due_valid_q <= 1'b0;
						for (int i = 0; i < OUTPUTS; i++) begin
							pat_q[i] <= pat_load[i];
						end
					end
					default: ;
				endcase
			end
			if (st_q == ST_RUN) begin
				if (uw.draw) begin
					case (ph_q)
						2'd0: begin
							lfsr_q <= lfsr_next;
							ph_q   <= 2'd1;
						end
						2'd1: ph_q <= 2'd2;
						default: ph_q <= 2'd0;
					endcase
				end
				if (exec) begin
					case (uw.act)
						A_FLIP: begin
							for (int i = 0; i < OUTPUTS; i++) begin
								if (OI_W'(i) == oi_q) begin
									pat_q[i] <= pat_q[i] ^ bit_r;
								end
							end
						end
						A_BK: begin
							for (int i = 0; i < OUTPUTS; i++) begin
								if (OI_W'(i) == oi_q) begin
									pat_q[i] <= pat_q[i] ^ (mask_q | bit_r);
								end
							end
						end
						default: ;
					endcase
					case (uw.br)
						BR_NEXT: pc_q <= pc_q + UPC_W'(1);
						BR_FAIL: pc_q <= cond ? pc_q + UPC_W'(1) : uw.target;
						BR_LOOP: pc_q <= (cnt_q != '0) ? uw.target : pc_q + UPC_W'(1);
						BR_END: begin
							st_q <= ST_IDLE;
						end
						default: pc_q <= UA_END;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_RUN) begin
			if (uw.draw && (ph_q == 2'd0)) begin
				x_q <= lfsr_next[DRAW_W-1:0];
			end
			if (uw.draw && (ph_q == 2'd1)) begin
				q_q <= prod[FRAC_W +: DRAW_W];
			end
			if (exec) begin
				case (uw.act)
					A_COUNT: cnt_q  <= r[CNT_W-1:0];
					A_OI:    oi_q   <= r[OI_W-1:0];
					A_BJ:    mask_q <= bit_r;
					default: ;
				endcase
				if (uw.br == BR_LOOP && cnt_q != '0) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
		if (accept || (exec && uw.br == BR_END)) begin
			out_fire_q    <= ((st_q == ST_RUN) || ((in_mode == MODE_TIME) && step_due)) ?
				fire_vec[FIRE_W-1:0] : '0;
			out_stepped_q <= (st_q == ST_RUN) || ((in_mode == MODE_TIME) && step_due);
			out_played_q  <= ((st_q == ST_IDLE) && (in_mode == MODE_TIME) && step_due) ?
				step_eff : '0;
			out_drift_q   <= (st_q == ST_RUN) ? drift_q : drift_d;
			out_level_q   <= (st_q == ST_RUN) ? level_q : level_d;
			out_rising_q  <= (st_q == ST_RUN) ? rising_q : rising_d;
		end
	end

	a_run_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN) |-> !m_valid_q)
		else $error("result pending while the mutation program runs");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RUN) |-> (pc_q <= UA_END))
		else $error("microprogram counter out of range");

	a_phase_draw: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_RUN) && (ph_q != 2'd0)) |-> uw.draw)
		else $error("draw phase advanced on a word without a draw");

	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && (uw.br == BR_END)) |=>
		(m_valid_q && (st_q == ST_IDLE) && out_stepped_q && (out_played_q == '0)))
		else $error("mutation end did not deliver the step zero result");

	a_mut_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_mode == MODE_TIME) && need_mut) |=>
		((st_q == ST_RUN) && (pc_q == UA_COUNT) && (ph_q == 2'd0)))
		else $error("bar start with drift did not start the mutation program");

endmodule

// ===== bench/mss_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mutating step sequencer scoreboard
// Follows configuration writes and input transactions, keeps its own copy of
// the sequencer state to work out each expected result, and compares every
// output transaction field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module mss_scoreboard (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [mss_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [mss_pkg::IN_USER_W-1:0]  s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [mss_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                           cfg_we,
	input  logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mss_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             failures,
	output int                             outstanding
);

	typedef struct packed {
		logic       ramping_up;
		logic [6:0] drift_level;
		logic       drift_on;
		logic [3:0] played_step;
		logic       stepped;
		logic [3:0] fire_mask;
	} seq_result_t;

	logic [15:0] base_pat [mss_pkg::BASE_REGS];
	logic [15:0] work_pat [mss_pkg::OUTPUTS];
	logic [31:0] seed_reg;
	logic [31:0] rng;
	logic [31:0] due_ms;
	logic        due_ok;
	logic        drift_en;
	logic        going_up;
	logic [3:0]  step_idx;
	logic [6:0]  drift_pct;
	seq_result_t expected_q [$];

	function automatic logic [31:0] rng_draw();
		logic lsb;
		lsb = rng[0];
		rng = rng >> 1;
		if (lsb) begin
			rng = rng ^ mss_pkg::LFSR_TAPS;
		end
		return {17'd0, rng[14:0]};
	endfunction

	task automatic reload_patterns();
		for (int i = 0; i < mss_pkg::OUTPUTS; i++) begin
			work_pat[i] = (i < mss_pkg::BASE_REGS) ? base_pat[i] : 16'd0;
		end
	endtask

	task automatic drift_clear();
		drift_en  = 1'b0;
		drift_pct = 7'd0;
		going_up  = 1'b1;
		step_idx  = 4'd0;
		due_ms    = 32'd0;
		due_ok    = 1'b0;
		reload_patterns();
	endtask

	task automatic mutate_patterns();
		int unsigned count;
		int unsigned oi;
		int unsigned bj;
		int unsigned bk;
		count = 1 + rng_draw() % 3;
		for (int unsigned m = 0; m < count; m++) begin
			if (rng_draw() % 100 < drift_pct) begin
				oi = rng_draw() % mss_pkg::OUTPUTS;
				bj = rng_draw() % mss_pkg::NUM_STEPS;
				work_pat[oi] = work_pat[oi] ^ 16'(1 << bj);
			end
		end
		if (rng_draw() % 100 < drift_pct / 2) begin
			oi = rng_draw() % mss_pkg::OUTPUTS;
			bj = rng_draw() % mss_pkg::NUM_STEPS;
			bk = rng_draw() % mss_pkg::NUM_STEPS;
			work_pat[oi] = work_pat[oi] ^ 16'((1 << bj) | (1 << bk));
		end
	endtask

	task automatic predict_step(input mss_pkg::mode_t mode, input logic [63:0] d,
			output seq_result_t r);
		logic [31:0] now;
		logic [31:0] span;
		logic [6:0]  lv;
		logic [3:0]  fire;
		r = '0;
		fire = '0;
		case (mode)
			mss_pkg::MODE_TIME: begin
				now  = d[31:0];
				span = {18'd0, d[47:34]};
				if (d[48]) begin
					step_idx = 4'd0;
				end
				if (d[49]) begin
					reload_patterns();
				end
				if (span < 32'(mss_pkg::MIN_STEP_MS)) begin
					span = 32'(mss_pkg::MIN_STEP_MS);
				end
				if (!due_ok) begin
					due_ms = now;
					due_ok = 1'b1;
				end
				if (now >= due_ms) begin
					due_ms = due_ms + span;
					if (due_ms < now) begin
						due_ms = now + span;
					end
					if (step_idx == 4'd0 && drift_en && drift_pct != 7'd0) begin
						mutate_patterns();
					end
					for (int i = 0; i < mss_pkg::OUTPUTS; i++) begin
						if (i < mss_pkg::FIRE_W && work_pat[i][step_idx]) begin
							fire[i] = 1'b1;
						end
					end
					r.fire_mask   = fire;
					r.stepped     = 1'b1;
					r.played_step = step_idx;
					step_idx      = step_idx + 4'd1;
				end
			end
			mss_pkg::MODE_BUTTON: begin
				if (!drift_en) begin
					drift_en  = 1'b1;
					drift_pct = 7'd10;
					going_up  = 1'b1;
				end else if (going_up) begin
					if (drift_pct >= 100) begin
						going_up  = 1'b0;
						drift_pct = 7'd90;
					end else begin
						drift_pct = (drift_pct + 10 > 100) ? 7'd100 : 7'(drift_pct + 10);
					end
				end else begin
					if (drift_pct == 0) begin
						going_up  = 1'b1;
						drift_pct = 7'd10;
					end else begin
						drift_pct = (drift_pct < 10) ? 7'd0 : 7'(drift_pct - 10);
					end
				end
			end
			mss_pkg::MODE_RESET: begin
				drift_clear();
			end
			default: begin
				lv        = d[57:51];
				drift_en  = d[50];
				drift_pct = (lv > 100) ? 7'd100 : lv;
				going_up  = d[58];
			end
		endcase
		r.drift_on    = drift_en;
		r.drift_level = drift_pct;
		r.ramping_up  = going_up;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			failures++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		seq_result_t want;
		seq_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < mss_pkg::BASE_REGS; i++) begin
				base_pat[i] = 16'd0;
			end
			seed_reg = mss_pkg::SEED_RESET;
			rng      = seed_reg;
			drift_clear();
			expected_q.delete();
			failures    = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index < mss_pkg::BASE_REGS) begin
					base_pat[cfg_index] = cfg_data[15:0];
				end else if (cfg_index == mss_pkg::REG_SEED) begin
					seed_reg = cfg_data;
					rng      = cfg_data;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_step(mss_pkg::mode_t'(s_axis_tuser), s_axis_tdata, want);
				expected_q.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = seq_result_t'(m_axis_tdata[17:0]);
				if (expected_q.size() == 0) begin
					failures++;
					$display("%0t: result with none expected, expected nothing, actual %h",
						$time, m_axis_tdata);
				end else begin
					want = expected_q.pop_front();
					check_field("fire_mask", want.fire_mask, got.fire_mask);
					check_field("stepped", want.stepped, got.stepped);
					check_field("played_step", want.played_step, got.played_step);
					check_field("drift_on", want.drift_on, got.drift_on);
					check_field("drift_level", want.drift_level, got.drift_level);
					check_field("ramping_up", want.ramping_up, got.ramping_up);
				end
			end
			outstanding = expected_q.size();
		end
	end

endmodule

// ===== bench/tb_mutating_step_sequencer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mutating step sequencer testbench
// Drives directed and random transactions through the stream input under
// several idle and stall mixes, reprograms the base patterns and seed between
// phases, and reports the scoreboard verdict once all results have drained.
// ----------------------------------------------------------------------------
module tb_mutating_step_sequencer;

	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [mss_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [mss_pkg::IN_USER_W-1:0]  s_axis_tuser  = '0;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [mss_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           cfg_we        = 1'b0;
	logic [mss_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [mss_pkg::CFG_DATA_W-1:0] cfg_data      = '0;
	int                             failures;
	int                             outstanding;

	int unsigned idle_pct   = 0;
	int unsigned stall_pct  = 0;
	logic        hold_armed = 1'b0;
	logic        hold_done  = 1'b0;
	int          hold_left  = 0;
	logic [31:0] clock_ms   = 32'd0;
	logic [15:0] tempo_now  = 16'd100;

	mutating_step_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	mss_scoreboard scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.failures      (failures),
		.outstanding   (outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

	// A requested hold keeps the output stalled long enough for the block to
	// back up into its input.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic logic [63:0] item_word(input logic [31:0] now,
			input logic [15:0] tempo, input logic sync, input logic reload,
			input logic act, input logic [6:0] lvl, input logic ramp);
		return {5'd0, ramp, lvl, act, reload, sync, tempo, now};
	endfunction

	task automatic send_item(input mss_pkg::mode_t mode, input logic [63:0] d);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_time(input logic [31:0] now, input logic [15:0] tempo,
			input logic sync, input logic reload);
		send_item(mss_pkg::MODE_TIME, item_word(now, tempo, sync, reload,
			1'($urandom), 7'($urandom), 1'($urandom)));
	endtask

	task automatic send_set(input logic act, input logic [6:0] lvl, input logic ramp);
		send_item(mss_pkg::MODE_SET, item_word($urandom, 16'($urandom), 1'($urandom),
			1'($urandom), act, lvl, ramp));
	endtask

	task automatic send_other(input mss_pkg::mode_t mode);
		send_item(mode, {5'd0, 59'({$urandom, $urandom})});
	endtask

	task automatic write_reg(input mss_pkg::cfg_reg_t idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [15:0] pa, input logic [15:0] pb,
			input logic [15:0] pc, input logic [15:0] pd, input logic [31:0] seed);
		write_reg(mss_pkg::REG_BASE_A, {16'd0, pa});
		write_reg(mss_pkg::REG_BASE_B, {16'd0, pb});
		write_reg(mss_pkg::REG_BASE_C, {16'd0, pc});
		write_reg(mss_pkg::REG_BASE_D, {16'd0, pd});
		write_reg(mss_pkg::REG_SEED, seed);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (64) @(posedge clk);
	endtask

	task automatic random_item();
		int unsigned pick;
		pick = $urandom_range(99);
		if ($urandom_range(49) == 0) begin
			tempo_now = ($urandom_range(3) == 0) ? 16'($urandom_range(400))
				: 16'($urandom_range(80));
		end
		if (pick < 70) begin
			clock_ms = clock_ms + $urandom_range(12);
			send_time(clock_ms, tempo_now, $urandom_range(19) == 0, $urandom_range(39) == 0);
		end else if (pick < 78) begin
			send_other(mss_pkg::MODE_BUTTON);
		end else if (pick < 84) begin
			send_set($urandom_range(3) != 0, 7'($urandom_range(127)), 1'($urandom));
		end else if (pick < 86) begin
			send_other(mss_pkg::MODE_RESET);
		end else if (pick < 93) begin
			clock_ms = $urandom;
			send_time(clock_ms, 16'($urandom), 1'($urandom), 1'($urandom));
		end else begin
			send_item(mss_pkg::mode_t'(2'($urandom_range(3))), {5'd0, 59'({$urandom, $urandom})});
		end
	endtask

	task automatic run_random(input int count);
		repeat (count) random_item();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(16'hFFFF, 16'h0001, 16'hAAAA, 16'h0000, 32'hFFFF_FFFF);
		send_time(32'd1000, 16'd0, 1'b0, 1'b1);
		send_time(32'd1004, 16'd3, 1'b0, 1'b0);
		send_time(32'd1005, 16'd19, 1'b0, 1'b0);
		send_other(mss_pkg::MODE_BUTTON);
		send_set(1'b1, 7'd127, 1'b1);
		send_other(mss_pkg::MODE_BUTTON);
		send_set(1'b1, 7'd5, 1'b0);
		send_other(mss_pkg::MODE_BUTTON);
		send_other(mss_pkg::MODE_BUTTON);
		send_set(1'b1, 7'd95, 1'b1);
		send_other(mss_pkg::MODE_BUTTON);
		send_time(32'd1010, 16'hFFFF, 1'b1, 1'b0);
		send_time(32'd50000, 16'd20, 1'b0, 1'b0);
		send_time(32'hFFFF_FFFE, 16'd40, 1'b1, 1'b1);
		send_time(32'd3, 16'd40, 1'b0, 1'b0);
		send_time(32'hFFFF_FFFF, 16'd400, 1'b0, 1'b0);
		send_set(1'b0, 7'd0, 1'b0);
		send_other(mss_pkg::MODE_RESET);
		send_time(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
		send_time(32'd0, 16'hFFFF, 1'b0, 1'b0);
		send_set(1'b1, 7'd100, 1'b0);
		send_time(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0);
		send_time(32'hFFFF_FFFF, 16'd7, 1'b0, 1'b1);
		drain();

		configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			$urandom | 32'd1);
		idle_pct  = 0;
		stall_pct = 0;
		run_random(265);
		drain();

		configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd1);
		idle_pct  = 85;
		stall_pct = 0;
		run_random(265);
		drain();

		configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		idle_pct  = 0;
		stall_pct = 85;
		run_random(265);
		drain();

		// A zero seed freezes the random source, so every draw reads zero.
		configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 32'd0);
		idle_pct  = 7;
		stall_pct = 7;
		run_random(265);
		drain();

		configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
		idle_pct   = 0;
		stall_pct  = 0;
		hold_armed <= 1'b1;
		run_random(60);
		drain();

		if (failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
